/* rtl/fisheye_point_distortion_macros.svh */
// ----------------------------------------------------------------------------
// fisheye point distortion assertion macros
// shared property forms for the port checker
// ----------------------------------------------------------------------------
`ifndef FISHEYE_POINT_DISTORTION_MACROS_SVH
`define FISHEYE_POINT_DISTORTION_MACROS_SVH

// same-cycle implication, idle in reset
`define FPD_ASSERT_IMPL(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("fpd check failed");

// next-cycle implication, idle in reset
`define FPD_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("fpd check failed");

// next-cycle implication, active in reset
`define FPD_ASSERT_ALWAYS(label, clk, ante, cons) \
  label: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("fpd check failed");

`endif

/* rtl/fpd_pkg.sv */
// ----------------------------------------------------------------------------
// fpd_pkg
// types, constants and helpers for the fisheye point distortion pipeline
// ----------------------------------------------------------------------------
package fpd_pkg;

  localparam int CORDIC_STAGES = 24;
  localparam int NUM_STAGES = (CORDIC_STAGES > 32) ? 32 : CORDIC_STAGES;

  localparam int CW = 52;
  localparam int AW = 34;

  localparam int MUL_LAT = 4;
  localparam int VEC_LAT = NUM_STAGES + MUL_LAT + 2;
  localparam int POLY_LAT = 5 * MUL_LAT + 3;
  localparam int ROT_LAT = NUM_STAGES + MUL_LAT + 2;
  localparam int TOTAL_LAT = 1 + 2 * VEC_LAT + POLY_LAT + ROT_LAT;

  localparam logic signed [AW-1:0] ANG_PI = 34'sd3373259426;
  localparam logic signed [AW-1:0] ANG_HALF_PI = 34'sd1686629713;
  localparam logic signed [63:0] GAIN_INV = 64'sd652032874;
  localparam logic signed [63:0] ONE_Q24 = 64'sd16777216;

  localparam logic signed [CW-1:0] SAT_MAX = CW'(64'sd2147483647);
  localparam logic signed [CW-1:0] SAT_MIN = -CW'(64'sd2147483648);

  localparam logic [31:0] ATAN_TAB [32] = '{
    32'd843314856, 32'd497837829, 32'd263043836, 32'd133525158, 32'd67021686,
    32'd33543515, 32'd16775850, 32'd8388437, 32'd4194282, 32'd2097149,
    32'd1048575, 32'd524287, 32'd262143, 32'd131071, 32'd65535, 32'd32767,
    32'd16383, 32'd8191, 32'd4095, 32'd2047, 32'd1023, 32'd511, 32'd255,
    32'd127, 32'd63, 32'd31, 32'd15, 32'd8, 32'd4, 32'd2, 32'd1, 32'd0
  };

  typedef enum logic [1:0] {
    REG_K1 = 2'd0,
    REG_K2 = 2'd1,
    REG_K3 = 2'd2,
    REG_K4 = 2'd3
  } reg_index_t;

  typedef struct packed {
    logic signed [31:0] point_x;
    logic signed [31:0] point_y;
    logic signed [31:0] point_z;
  } point_t;

  typedef struct packed {
    logic signed [31:0] image_x;
    logic signed [31:0] image_y;
  } image_t;

  typedef struct packed {
    logic signed [31:0] k1;
    logic signed [31:0] k2;
    logic signed [31:0] k3;
    logic signed [31:0] k4;
  } coeff_t;

  // q.24 round to q16.16 and clamp to 32 bits
  function automatic logic [31:0] sat_q16(input logic signed [CW-1:0] v);
    logic signed [CW-1:0] s;
    s = (v + CW'(128)) >>> 8;
    if (s > SAT_MAX) begin
      return 32'h7fff_ffff;
    end else if (s < SAT_MIN) begin
      return 32'h8000_0000;
    end
    return s[31:0];
  endfunction

endpackage

/* rtl/fpd_mul.sv */
// ----------------------------------------------------------------------------
// fpd_mul
// pipelined signed fixed-point multiply, rounded half away from zero
// ----------------------------------------------------------------------------
module fpd_mul (
  input  logic               clk,
  input  logic               en,
  input  logic signed [63:0] a,
  input  logic signed [63:0] b,
  input  logic               frac30,
  output logic signed [63:0] p
);

  logic [31:0] ma;
  logic [63:0] mb;
  logic        neg1;
  logic [63:0] pl;
  logic [63:0] ph;
  logic        neg2;
  logic [63:0] mag;
  logic        neg3;
  logic [95:0] sum;
  logic [63:0] abs_a;

  assign abs_a = a[63] ? 64'(-a) : 64'(a);

  always_comb begin
    sum = {ph, 32'b0} + {32'b0, pl} + (frac30 ? 96'd536870912 : 96'd8388608);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ma <= abs_a[31:0];
      mb <= b[63] ? 64'(-b) : 64'(b);
      neg1 <= a[63] ^ b[63];
      pl <= 64'(ma) * 64'(mb[31:0]);
      ph <= 64'(ma) * 64'(mb[63:32]);
      neg2 <= neg1;
      mag <= frac30 ? sum[93:30] : sum[87:24];
      neg3 <= neg2;
      p <= neg3 ? -$signed(mag) : $signed(mag);
    end
  end

endmodule

/* rtl/fpd_vec.sv */
// ----------------------------------------------------------------------------
// fpd_vec
// vectoring cordic pipeline: angle and gain-corrected radius of (x, y)
// ----------------------------------------------------------------------------
module fpd_vec (
  input  logic                              clk,
  input  logic                              en,
  input  logic signed [fpd_pkg::CW-1:0]     vy,
  input  logic signed [fpd_pkg::CW-1:0]     vx,
  output logic signed [fpd_pkg::AW-1:0]     ang,
  output logic signed [fpd_pkg::CW-1:0]     mag
);

  localparam int NS = fpd_pkg::NUM_STAGES;
  localparam int CW = fpd_pkg::CW;
  localparam int AW = fpd_pkg::AW;
  localparam int ML = fpd_pkg::MUL_LAT;

  logic signed [CW-1:0] x [NS+1];
  logic signed [CW-1:0] y [NS+1];
  logic signed [AW-1:0] z [NS+1];
  logic                 spec [NS+1];
  logic signed [CW-1:0] smag [NS+1];
  logic signed [AW-1:0] sang [NS+1];

  logic                 spec_d [ML];
  logic signed [CW-1:0] smag_d [ML];
  logic signed [AW-1:0] sang_d [ML];
  logic signed [AW-1:0] z_d [ML];
  logic signed [63:0]   gp;

  always_ff @(posedge clk) begin
    if (en) begin
      spec[0] <= (vy == '0);
      sang[0] <= vx[CW-1] ? fpd_pkg::ANG_PI : '0;
      smag[0] <= vx[CW-1] ? -vx : vx;
      x[0] <= vx[CW-1] ? -vx : vx;
      y[0] <= vx[CW-1] ? -vy : vy;
      if (vx[CW-1]) begin
        z[0] <= vy[CW-1] ? -fpd_pkg::ANG_PI : fpd_pkg::ANG_PI;
      end else begin
        z[0] <= '0;
      end
    end
  end

  for (genvar i = 0; i < NS; i++) begin : g_stage
    localparam logic signed [AW-1:0] ATN = AW'(fpd_pkg::ATAN_TAB[i]);
    always_ff @(posedge clk) begin
      if (en) begin
        spec[i+1] <= spec[i];
        smag[i+1] <= smag[i];
        sang[i+1] <= sang[i];
        if (y[i][CW-1]) begin
          x[i+1] <= x[i] - (y[i] >>> i);
          y[i+1] <= y[i] + (x[i] >>> i);
          z[i+1] <= z[i] - ATN;
        end else begin
          x[i+1] <= x[i] + (y[i] >>> i);
          y[i+1] <= y[i] - (x[i] >>> i);
          z[i+1] <= z[i] + ATN;
        end
      end
    end
  end

  fpd_mul u_gain (
    .clk    (clk),
    .en     (en),
    .a      (fpd_pkg::GAIN_INV),
    .b      ({{(64-CW){x[NS][CW-1]}}, x[NS]}),
    .frac30 (1'b1),
    .p      (gp)
  );

  always_ff @(posedge clk) begin
    if (en) begin
      spec_d[0] <= spec[NS];
      smag_d[0] <= smag[NS];
      sang_d[0] <= sang[NS];
      z_d[0] <= z[NS];
      for (int k = 1; k < ML; k++) begin
        spec_d[k] <= spec_d[k-1];
        smag_d[k] <= smag_d[k-1];
        sang_d[k] <= sang_d[k-1];
        z_d[k] <= z_d[k-1];
      end
      ang <= spec_d[ML-1] ? sang_d[ML-1] : z_d[ML-1];
      mag <= spec_d[ML-1] ? smag_d[ML-1] : gp[CW-1:0];
    end
  end

endmodule

/* rtl/fpd_poly.sv */
// ----------------------------------------------------------------------------
// fpd_poly
// angular polynomial: theta_d = theta * (1 + k1 t^2 + k2 t^4 + k3 t^6 + k4 t^8)
// ----------------------------------------------------------------------------
module fpd_poly (
  input  logic                          clk,
  input  logic                          en,
  input  logic signed [fpd_pkg::AW-1:0] theta,
  input  fpd_pkg::coeff_t               coeff,
  output logic signed [63:0]            td
);

  localparam int AW = fpd_pkg::AW;
  localparam int ML = fpd_pkg::MUL_LAT;
  localparam int T1_DLY = 4 * ML + 2;

  logic signed [AW-1:0] tr;
  logic signed [63:0]   t1;
  logic signed [63:0]   t2;
  logic signed [63:0]   t4;
  logic signed [63:0]   t6;
  logic signed [63:0]   t8;
  logic signed [63:0]   a1;
  logic signed [63:0]   a2;
  logic signed [63:0]   a3;
  logic signed [63:0]   a4;
  logic signed [63:0]   t1_d [T1_DLY];
  logic signed [63:0]   t2_d [ML];
  logic signed [63:0]   a1_d [2*ML];
  logic signed [63:0]   a2_d [ML];
  logic signed [63:0]   sum_lo;
  logic signed [63:0]   sum_hi;
  logic signed [63:0]   poly;

  assign tr = theta + AW'(32);

  always_ff @(posedge clk) begin
    if (en) begin
      t1 <= {{(64-AW+6){tr[AW-1]}}, tr[AW-1:6]};
      t1_d[0] <= t1;
      for (int k = 1; k < T1_DLY; k++) begin
        t1_d[k] <= t1_d[k-1];
      end
      t2_d[0] <= t2;
      a2_d[0] <= a2;
      for (int k = 1; k < ML; k++) begin
        t2_d[k] <= t2_d[k-1];
        a2_d[k] <= a2_d[k-1];
      end
      a1_d[0] <= a1;
      for (int k = 1; k < 2 * ML; k++) begin
        a1_d[k] <= a1_d[k-1];
      end
      sum_lo <= a1_d[2*ML-1] + a2_d[ML-1];
      sum_hi <= a3 + a4;
      poly <= fpd_pkg::ONE_Q24 + sum_lo + sum_hi;
    end
  end

  fpd_mul u_t2 (.clk(clk), .en(en), .a(t1), .b(t1), .frac30(1'b0), .p(t2));
  fpd_mul u_t4 (.clk(clk), .en(en), .a(t2), .b(t2), .frac30(1'b0), .p(t4));
  fpd_mul u_a1 (.clk(clk), .en(en), .a(64'(coeff.k1)), .b(t2), .frac30(1'b0), .p(a1));
  fpd_mul u_t6 (.clk(clk), .en(en), .a(t4), .b(t2_d[ML-1]), .frac30(1'b0), .p(t6));
  fpd_mul u_t8 (.clk(clk), .en(en), .a(t4), .b(t4), .frac30(1'b0), .p(t8));
  fpd_mul u_a2 (.clk(clk), .en(en), .a(64'(coeff.k2)), .b(t4), .frac30(1'b0), .p(a2));
  fpd_mul u_a3 (.clk(clk), .en(en), .a(64'(coeff.k3)), .b(t6), .frac30(1'b0), .p(a3));
  fpd_mul u_a4 (.clk(clk), .en(en), .a(64'(coeff.k4)), .b(t8), .frac30(1'b0), .p(a4));
  fpd_mul u_td (
    .clk    (clk),
    .en     (en),
    .a      (t1_d[T1_DLY-1]),
    .b      (poly),
    .frac30 (1'b0),
    .p      (td)
  );

endmodule

/* rtl/fpd_rot.sv */
// ----------------------------------------------------------------------------
// fpd_rot
// rotation cordic pipeline: turns (theta_d, 0) by psi, or passes it on axis; rounds and saturates
// ----------------------------------------------------------------------------
module fpd_rot (
  input  logic                          clk,
  input  logic                          en,
  input  logic signed [63:0]            td,
  input  logic signed [fpd_pkg::AW-1:0] psi,
  input  logic                          axis,
  output fpd_pkg::image_t               image
);

  localparam int NS = fpd_pkg::NUM_STAGES;
  localparam int CW = fpd_pkg::CW;
  localparam int AW = fpd_pkg::AW;
  localparam int ML = fpd_pkg::MUL_LAT;

  logic signed [CW-1:0] x [NS+1];
  logic signed [CW-1:0] y [NS+1];
  logic signed [AW-1:0] z [NS+1];
  logic                 ax [NS+1];
  logic signed [CW-1:0] tb [NS+1];
  logic                 ax_d [ML];
  logic signed [CW-1:0] tb_d [ML];
  logic signed [63:0]   gx;
  logic signed [63:0]   gy;
  logic signed [CW-1:0] tdn;

  assign tdn = td[CW-1:0];

  always_ff @(posedge clk) begin
    if (en) begin
      ax[0] <= axis;
      tb[0] <= tdn;
      y[0] <= '0;
      if (psi > fpd_pkg::ANG_HALF_PI) begin
        z[0] <= psi - fpd_pkg::ANG_PI;
        x[0] <= -tdn;
      end else if (psi < -fpd_pkg::ANG_HALF_PI) begin
        z[0] <= psi + fpd_pkg::ANG_PI;
        x[0] <= -tdn;
      end else begin
        z[0] <= psi;
        x[0] <= tdn;
      end
    end
  end

  for (genvar i = 0; i < NS; i++) begin : g_stage
    localparam logic signed [AW-1:0] ATN = AW'(fpd_pkg::ATAN_TAB[i]);
    always_ff @(posedge clk) begin
      if (en) begin
        ax[i+1] <= ax[i];
        tb[i+1] <= tb[i];
        if (!z[i][AW-1]) begin
          x[i+1] <= x[i] - (y[i] >>> i);
          y[i+1] <= y[i] + (x[i] >>> i);
          z[i+1] <= z[i] - ATN;
        end else begin
          x[i+1] <= x[i] + (y[i] >>> i);
          y[i+1] <= y[i] - (x[i] >>> i);
          z[i+1] <= z[i] + ATN;
        end
      end
    end
  end

  fpd_mul u_gain_x (
    .clk    (clk),
    .en     (en),
    .a      (fpd_pkg::GAIN_INV),
    .b      ({{(64-CW){x[NS][CW-1]}}, x[NS]}),
    .frac30 (1'b1),
    .p      (gx)
  );

  fpd_mul u_gain_y (
    .clk    (clk),
    .en     (en),
    .a      (fpd_pkg::GAIN_INV),
    .b      ({{(64-CW){y[NS][CW-1]}}, y[NS]}),
    .frac30 (1'b1),
    .p      (gy)
  );

  always_ff @(posedge clk) begin
    if (en) begin
      ax_d[0] <= ax[NS];
      tb_d[0] <= tb[NS];
      for (int k = 1; k < ML; k++) begin
        ax_d[k] <= ax_d[k-1];
        tb_d[k] <= tb_d[k-1];
      end
      if (ax_d[ML-1]) begin
        image.image_x <= fpd_pkg::sat_q16(tb_d[ML-1]);
        image.image_y <= '0;
      end else begin
        image.image_x <= fpd_pkg::sat_q16(gx[CW-1:0]);
        image.image_y <= fpd_pkg::sat_q16(gy[CW-1:0]);
      end
    end
  end

endmodule

/* rtl/fisheye_point_distortion.sv */
// ----------------------------------------------------------------------------
// fisheye_point_distortion
// throughput: one point per cycle unless the output stalls; set by the three fully unrolled cordic pipes
// a stalled output holds the whole pipeline, nothing is dropped or repeated
// reset: synchronous; clears valid bits and loads the default coefficients
// ----------------------------------------------------------------------------
module fisheye_point_distortion (
  input  logic            clk,
  input  logic            rst,
  input  logic            point_valid,
  output logic            point_stall,
  input  fpd_pkg::point_t point,
  output logic            image_valid,
  input  logic            image_stall,
  output fpd_pkg::image_t image,
  input  logic            cfg_we,
  input  logic [1:0]      cfg_index,
  input  logic [31:0]     cfg_data
);

  localparam int CW = fpd_pkg::CW;
  localparam int AW = fpd_pkg::AW;
  localparam int TL = fpd_pkg::TOTAL_LAT;
  localparam int ZS_DLY = fpd_pkg::VEC_LAT;
  localparam int PSI_DLY = fpd_pkg::VEC_LAT + fpd_pkg::POLY_LAT;
  localparam int AXIS_DLY = 2 * fpd_pkg::VEC_LAT + fpd_pkg::POLY_LAT;

  fpd_pkg::coeff_t      coeff;
  logic                 en;
  logic [TL-1:0]        vld;
  logic signed [CW-1:0] xs;
  logic signed [CW-1:0] ys;
  logic signed [CW-1:0] zs;
  logic                 axis;
  logic signed [CW-1:0] zs_d [ZS_DLY];
  logic signed [AW-1:0] psi_d [PSI_DLY];
  logic                 axis_d [AXIS_DLY];
  logic signed [AW-1:0] psi;
  logic signed [CW-1:0] r;
  logic signed [AW-1:0] theta;
  logic signed [63:0]   td;

  assign en = !(image_valid && image_stall);
  assign point_stall = !en;
  assign image_valid = vld[TL-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      coeff.k1 <= 32'sd5619724;
      coeff.k2 <= 32'sd1980825;
      coeff.k3 <= 32'sd1546047;
      coeff.k4 <= 32'sd0;
    end else if (cfg_we) begin
      unique case (fpd_pkg::reg_index_t'(cfg_index))
        fpd_pkg::REG_K1: coeff.k1 <= cfg_data;
        fpd_pkg::REG_K2: coeff.k2 <= cfg_data;
        fpd_pkg::REG_K3: coeff.k3 <= cfg_data;
        fpd_pkg::REG_K4: coeff.k4 <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[TL-2:0], point_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      xs <= {{(CW-48){point.point_x[31]}}, point.point_x, 16'b0};
      ys <= {{(CW-48){point.point_y[31]}}, point.point_y, 16'b0};
      zs <= {{(CW-48){point.point_z[31]}}, point.point_z, 16'b0};
      axis <= (point.point_x == '0) && (point.point_y == '0);
      zs_d[0] <= zs;
      for (int k = 1; k < ZS_DLY; k++) begin
        zs_d[k] <= zs_d[k-1];
      end
      psi_d[0] <= psi;
      for (int k = 1; k < PSI_DLY; k++) begin
        psi_d[k] <= psi_d[k-1];
      end
      axis_d[0] <= axis;
      for (int k = 1; k < AXIS_DLY; k++) begin
        axis_d[k] <= axis_d[k-1];
      end
    end
  end

  // azimuth and radius in the image plane
  fpd_vec u_vec_psi (
    .clk (clk),
    .en  (en),
    .vy  (ys),
    .vx  (xs),
    .ang (psi),
    .mag (r)
  );

  // off-axis angle
  fpd_vec u_vec_theta (
    .clk (clk),
    .en  (en),
    .vy  (r),
    .vx  (zs_d[ZS_DLY-1]),
    .ang (theta),
    .mag ()
  );

  fpd_poly u_poly (
    .clk   (clk),
    .en    (en),
    .theta (theta),
    .coeff (coeff),
    .td    (td)
  );

  fpd_rot u_rot (
    .clk   (clk),
    .en    (en),
    .td    (td),
    .psi   (psi_d[PSI_DLY-1]),
    .axis  (axis_d[AXIS_DLY-1]),
    .image (image)
  );

endmodule

/* rtl/fpd_checker.sv */
// ----------------------------------------------------------------------------
// fpd_checker
// port-level checks on the distortion pipeline handshakes
// ----------------------------------------------------------------------------
`include "fisheye_point_distortion_macros.svh"

module fpd_checker (
  input logic            clk,
  input logic            rst,
  input logic            point_stall,
  input logic            image_valid,
  input logic            image_stall,
  input fpd_pkg::image_t image
);

  // input backpressure only comes from a held output transaction
  `FPD_ASSERT_IMPL(a_stall_source, clk, rst, point_stall, image_valid && image_stall)

  // free output side never blocks the input
  `FPD_ASSERT_IMPL(a_no_false_stall, clk, rst, !image_stall, !point_stall)

  // a held output transaction keeps its payload
  `FPD_ASSERT_NEXT(a_hold, clk, rst, image_valid && image_stall,
                   image_valid && $stable(image))

  // pipeline is empty right after reset
  `FPD_ASSERT_ALWAYS(a_reset_empty, clk, rst, !image_valid)

endmodule

bind fisheye_point_distortion fpd_checker u_fpd_checker (.*);

/* verif/tb_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// checks fisheye_point_distortion against a bit-exact fixed-point predictor
// directed points cover the origin, the optical axis, the axes, the half-planes
// and the full-scale corners; random points follow under three stall patterns
// and several coefficient sets, including the register extremes
// ----------------------------------------------------------------------------
module tb_top;

  localparam int DRAIN_CYCLES = fpd_pkg::TOTAL_LAT + 16;
  localparam int STALL_LIMIT = 20000;

  logic clk;
  logic rst;
  logic point_valid;
  logic point_stall;
  fpd_pkg::point_t point;
  logic image_valid;
  logic image_stall;
  fpd_pkg::image_t image;
  logic cfg_we;
  logic [1:0] cfg_index;
  logic [31:0] cfg_data;

  fpd_pkg::image_t pending_images[$];
  longint coeff[4];
  int send_idle_pct;
  int recv_idle_pct;
  int points_sent;
  int images_checked;
  int mismatches;
  int quiet_cycles;

  fisheye_point_distortion dut (
    .clk(clk), .rst(rst),
    .point_valid(point_valid), .point_stall(point_stall), .point(point),
    .image_valid(image_valid), .image_stall(image_stall), .image(image),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always begin
    clk = 1'b1;
    #6;
    clk = 1'b0;
    #6;
  end

  // round half away from zero, with the same 64-bit wraparound as the hardware
  function automatic longint mul_round(longint a, longint b, int f);
    bit neg;
    bit [63:0] ma, mb, mask, hi, lo;
    neg = (a < 0) != (b < 0);
    ma = (a < 0) ? 64'd0 - a : a;
    mb = (b < 0) ? 64'd0 - b : b;
    mask = (64'd1 << f) - 64'd1;
    hi = ma * (mb >> f);
    lo = (ma * (mb & mask) + (64'd1 << (f - 1))) >> f;
    return neg ? -longint'(hi + lo) : longint'(hi + lo);
  endfunction

  function automatic longint vector_angle(longint y, longint x, output longint radius);
    longint ang, nx, ny;
    ang = 0;
    if (y == 0) begin
      radius = (x < 0) ? -x : x;
      return (x < 0) ? longint'(fpd_pkg::ANG_PI) : 0;
    end
    if (x < 0) begin
      ang = (y >= 0) ? longint'(fpd_pkg::ANG_PI) : -longint'(fpd_pkg::ANG_PI);
      x = -x;
      y = -y;
    end
    for (int i = 0; i < fpd_pkg::NUM_STAGES; i++) begin
      if (y < 0) begin
        nx = x - (y >>> i);
        ny = y + (x >>> i);
        ang -= longint'(fpd_pkg::ATAN_TAB[i]);
      end else begin
        nx = x + (y >>> i);
        ny = y - (x >>> i);
        ang += longint'(fpd_pkg::ATAN_TAB[i]);
      end
      x = nx;
      y = ny;
    end
    radius = mul_round(longint'(fpd_pkg::GAIN_INV), x, 30);
    return ang;
  endfunction

  function automatic logic [31:0] clamp_q16(longint v);
    v = (v + 128) >>> 8;
    if (v > 64'sd2147483647) return 32'h7fff_ffff;
    if (v < -64'sd2147483648) return 32'h8000_0000;
    return v[31:0];
  endfunction

  function automatic fpd_pkg::image_t distort_point(fpd_pkg::point_t p);
    longint px, py, pz, r, unused, psi, theta, t1, t2, t4, t6, t8, poly, td;
    longint vx, vy, ang, nx, ny;
    fpd_pkg::image_t res;
    px = p.point_x;
    py = p.point_y;
    pz = p.point_z;
    psi = vector_angle(py * 65536, px * 65536, r);
    theta = vector_angle(r, pz * 65536, unused);
    t1 = (theta + 32) >>> 6;
    t2 = mul_round(t1, t1, 24);
    t4 = mul_round(t2, t2, 24);
    t6 = mul_round(t4, t2, 24);
    t8 = mul_round(t4, t4, 24);
    poly = longint'(fpd_pkg::ONE_Q24) + mul_round(coeff[fpd_pkg::REG_K1], t2, 24)
         + mul_round(coeff[fpd_pkg::REG_K2], t4, 24)
         + mul_round(coeff[fpd_pkg::REG_K3], t6, 24)
         + mul_round(coeff[fpd_pkg::REG_K4], t8, 24);
    td = mul_round(t1, poly, 24);
    if (px == 0 && py == 0) begin
      res.image_x = clamp_q16(td);
      res.image_y = '0;
      return res;
    end
    vx = td;
    vy = 0;
    ang = psi;
    if (ang > longint'(fpd_pkg::ANG_HALF_PI)) begin
      ang -= longint'(fpd_pkg::ANG_PI);
      vx = -vx;
    end else if (ang < -longint'(fpd_pkg::ANG_HALF_PI)) begin
      ang += longint'(fpd_pkg::ANG_PI);
      vx = -vx;
    end
    for (int i = 0; i < fpd_pkg::NUM_STAGES; i++) begin
      if (ang >= 0) begin
        nx = vx - (vy >>> i);
        ny = vy + (vx >>> i);
        ang -= longint'(fpd_pkg::ATAN_TAB[i]);
      end else begin
        nx = vx + (vy >>> i);
        ny = vy - (vx >>> i);
        ang += longint'(fpd_pkg::ATAN_TAB[i]);
      end
      vx = nx;
      vy = ny;
    end
    res.image_x = clamp_q16(mul_round(longint'(fpd_pkg::GAIN_INV), vx, 30));
    res.image_y = clamp_q16(mul_round(longint'(fpd_pkg::GAIN_INV), vy, 30));
    return res;
  endfunction

  // result side: check, random stall, watchdog
  always @(posedge clk) begin
    fpd_pkg::image_t want;
    if (rst) begin
      image_stall <= 1'b0;
      quiet_cycles <= 0;
    end else begin
      image_stall <= ($urandom_range(99) < recv_idle_pct);
      if ((image_valid && !image_stall) || (point_valid && !point_stall)) begin
        quiet_cycles <= 0;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("%0t: timeout, %0d transactions outstanding", $time,
                 pending_images.size());
        $display("Simulation FAILED");
        $finish;
      end
      if (image_valid && !image_stall) begin
        if (pending_images.size() == 0) begin
          $display("%0t: unexpected image transaction x=%h y=%h", $time,
                   image.image_x, image.image_y);
          mismatches++;
        end else begin
          want = pending_images.pop_front();
          images_checked++;
          if (image.image_x !== want.image_x) begin
            $display("%0t: image_x expected %h actual %h", $time, want.image_x,
                     image.image_x);
            mismatches++;
          end
          if (image.image_y !== want.image_y) begin
            $display("%0t: image_y expected %h actual %h", $time, want.image_y,
                     image.image_y);
            mismatches++;
          end
        end
      end
    end
  end

  task automatic send_point(fpd_pkg::point_t p);
    while ($urandom_range(99) < send_idle_pct) begin
      point_valid <= 1'b0;
      @(posedge clk);
    end
    point_valid <= 1'b1;
    point <= p;
    @(posedge clk);
    while (point_stall) @(posedge clk);
    pending_images.push_back(distort_point(p));
    points_sent++;
  endtask

  task automatic drain;
    point_valid <= 1'b0;
    @(posedge clk);
    while (pending_images.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_coeffs(logic [31:0] k1, logic [31:0] k2, logic [31:0] k3,
                              logic [31:0] k4);
    logic [31:0] vals[4];
    vals = '{k1, k2, k3, k4};
    drain();
    for (int i = 0; i < 4; i++) begin
      cfg_we <= 1'b1;
      cfg_index <= fpd_pkg::reg_index_t'(i);
      cfg_data <= vals[i];
      @(posedge clk);
      coeff[i] = longint'(signed'(vals[i]));
    end
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  function automatic fpd_pkg::point_t make_point(logic [31:0] x, logic [31:0] y,
                                                 logic [31:0] z);
    fpd_pkg::point_t p;
    p.point_x = x;
    p.point_y = y;
    p.point_z = z;
    return p;
  endfunction

  function automatic logic [31:0] rand_coord();
    case ($urandom_range(3))
      0: return $urandom();
      1: return 32'($signed($urandom_range(131072)) - 65536);
      2: return 32'($signed($urandom_range(2097152)) - 1048576);
      default: return 32'($signed($urandom_range(16)) - 8);
    endcase
  endfunction

  task automatic test_directed;
    send_point(make_point(32'd0, 32'd0, 32'd0));
    send_point(make_point(32'd0, 32'd0, 32'h0001_0000));
    send_point(make_point(32'd0, 32'd0, 32'hffff_0000));
    send_point(make_point(32'd0, 32'd0, 32'h8000_0000));
    send_point(make_point(32'd0, 32'd0, 32'h7fff_ffff));
    send_point(make_point(32'h0001_0000, 32'd0, 32'h0001_0000));
    send_point(make_point(32'hffff_0000, 32'd0, 32'h0001_0000));
    send_point(make_point(32'd0, 32'h0001_0000, 32'h0001_0000));
    send_point(make_point(32'd0, 32'hffff_0000, 32'h0001_0000));
    send_point(make_point(32'hffff_0000, 32'h0000_8000, 32'h0002_0000));
    send_point(make_point(32'hffff_0000, 32'hffff_8000, 32'h0002_0000));
    send_point(make_point(32'h0001_0000, 32'h0001_0000, 32'd0));
    send_point(make_point(32'h0001_0000, 32'h0001_0000, 32'hffff_0000));
    send_point(make_point(32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff));
    send_point(make_point(32'h8000_0000, 32'h8000_0000, 32'h8000_0000));
    send_point(make_point(32'h8000_0000, 32'h7fff_ffff, 32'd1));
    send_point(make_point(32'h8000_0000, 32'd0, 32'h0001_0000));
    send_point(make_point(32'd1, 32'd0, 32'h7fff_ffff));
    send_point(make_point(32'hffff_ffff, 32'hffff_ffff, 32'h0000_0001));
    drain();
  endtask

  task automatic test_random_points(int count, int send_pct, int recv_pct);
    send_idle_pct = send_pct;
    recv_idle_pct = recv_pct;
    for (int i = 0; i < count; i++) begin
      send_point(make_point(rand_coord(), rand_coord(), rand_coord()));
    end
    drain();
  endtask

  task automatic test_coeff_extremes;
    write_coeffs(32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff);
    test_random_points(35, 0, 0);
    write_coeffs(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
    test_random_points(35, 0, 0);
    write_coeffs(32'd0, 32'd0, 32'd0, 32'd0);
    test_random_points(35, 0, 0);
  endtask

  initial begin
    rst = 1'b1;
    point_valid = 1'b0;
    point = '0;
    cfg_we = 1'b0;
    cfg_index = fpd_pkg::REG_K1;
    cfg_data = '0;
    send_idle_pct = 29;
    recv_idle_pct = 88;
    points_sent = 0;
    images_checked = 0;
    mismatches = 0;
    coeff[fpd_pkg::REG_K1] = 5619724;
    coeff[fpd_pkg::REG_K2] = 1980825;
    coeff[fpd_pkg::REG_K3] = 1546047;
    coeff[fpd_pkg::REG_K4] = 0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_directed();
    test_random_points(300, 29, 88);
    write_coeffs($urandom_range(33554432), 32'($signed($urandom_range(16777216)) - 8388608),
                 $urandom(), $urandom());
    test_random_points(300, 88, 29);
    test_coeff_extremes();
    write_coeffs(32'd5619724, 32'd1980825, 32'd1546047, 32'h0010_0000);
    test_random_points(300, 0, 0);

    $display("covered %0d points, %0d image transactions checked, %0d mismatches",
             points_sent, images_checked, mismatches);
    $display("axis, half-plane and full-scale points, random and extreme coefficients");
    if (mismatches == 0 && pending_images.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

/* files.f */
+incdir+rtl
rtl/fpd_pkg.sv
rtl/fpd_mul.sv
rtl/fpd_vec.sv
rtl/fpd_poly.sv
rtl/fpd_rot.sv
rtl/fisheye_point_distortion.sv
rtl/fpd_checker.sv
verif/tb_top.sv
